// ===== src/assert_macros.svh =====
// assertion helpers, included by rua_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside reset
`define RUA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define RUA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rua_pkg.sv =====
// ----------------------------------------------------------------------------
// rua_pkg
// Shared types and constants of the rectangle union area sweep.
// ----------------------------------------------------------------------------
package rua_pkg;

    localparam int MAX_LEAVES_DEF = 1024;

    // opcode values of an input transaction
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    // register indexes
    localparam logic REG_USED_LEAVES = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_ACC,
        ST_WALK,
        ST_RMW,
        ST_OUT
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_step;
        logic latch;
        logic tbl_wr;
        logic mul;
        logic acc;
        logic push_kids;
        logic issue_rd;
        logic write_node;
        logic pop;
        logic out_load;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_done;
        logic is_edge;
        logic stk_empty;
        logic top_oob;
        logic top_visit;
    } status_t;

endpackage

// ===== src/rua_ctrl.sv =====
// ----------------------------------------------------------------------------
// rua_ctrl
// Sequencer: clearing pass, item decode, tree walk and result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rua_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  rua_pkg::status_t sts,
    output rua_pkg::cmd_t    cmd
);
    import rua_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (sts.clr_done) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_EXEC;
            ST_EXEC:  state_next = sts.is_edge ? ST_ACC : ST_OUT;
            ST_ACC:   state_next = ST_WALK;
            ST_WALK:
            begin
                if (sts.stk_empty)
                    state_next = ST_OUT;
                else if (!sts.top_oob && sts.top_visit)
                    state_next = ST_RMW;
            end
            ST_RMW:   state_next = ST_WALK;
            ST_OUT:   if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR: cmd.clr_step = 1'b1;
            ST_IDLE:  cmd.latch = in_valid;
            ST_EXEC:
            begin
                cmd.tbl_wr = !sts.is_edge;
                cmd.mul    = sts.is_edge;
            end
            ST_ACC:   cmd.acc = 1'b1;
            ST_WALK:
            begin
                if (!sts.stk_empty)
                begin
                    if (sts.top_oob)
                        cmd.pop = 1'b1;
                    else if (sts.top_visit)
                        cmd.issue_rd = 1'b1;
                    else
                        cmd.push_kids = 1'b1;
                end
            end
            ST_RMW:
            begin
                cmd.write_node = 1'b1;
                cmd.pop        = 1'b1;
            end
            ST_OUT:   cmd.out_load = slot_free;
            default:  cmd = '0;
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    `RUA_ASSERT(a_rmw_after_walk, (state_reg == ST_RMW) |-> ($past(state_reg) == ST_WALK), "node write without read")
    `RUA_ASSERT(a_out_rise, $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT), "result not from handoff state")
    `RUA_ASSERT_ALWAYS(a_clear_stall, (state_reg == ST_CLEAR) |-> in_stall, "transaction during clearing pass")

endmodule

// ===== src/rua_dp.sv =====
// ----------------------------------------------------------------------------
// rua_dp
// Datapath: coordinate table, tree memories, walk stack and area accumulator.
// ----------------------------------------------------------------------------
module rua_dp #(
    parameter int MAX_LEAVES = rua_pkg::MAX_LEAVES_DEF,
    localparam int TW = $clog2(MAX_LEAVES + 2)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rua_pkg::cmd_t        cmd,
    output rua_pkg::status_t     sts,
    input  logic [TW-1:0]        used_leaves,
    input  logic                 opcode,
    input  logic [10:0]          coord_index,
    input  logic signed [30:0]   coord_value,
    input  logic signed [30:0]   edge_y,
    input  logic [10:0]          range_low,
    input  logic [10:0]          range_high,
    input  logic signed [1:0]    delta,
    output logic signed [63:0]   area,
    output logic [30:0]          covered_length
);
    import rua_pkg::*;

    localparam int TREE   = 4 * MAX_LEAVES;
    localparam int NODE_W = $clog2(TREE);
    localparam int TDEPTH = MAX_LEAVES + 2;
    localparam int LEVELS = $clog2(MAX_LEAVES) + 2;
    localparam int DEPTH  = 2 * LEVELS + 2;
    localparam int SPC    = $clog2(DEPTH + 1);
    localparam int SPI    = $clog2(DEPTH);

    // memories
    logic [31:0] tab_mem [TDEPTH];
    logic [15:0] cnt_mem [TREE];
    logic [31:0] len_mem [TREE];

    // latched transaction
    logic               op_reg;
    logic [10:0]        cidx_reg;
    logic signed [30:0] cval_reg;
    logic signed [30:0] y_reg;
    logic [10:0]        rlo_reg;
    logic [10:0]        rhi_reg;
    logic signed [1:0]  d_reg;

    // sweep state
    logic signed [30:0] prev_y_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] area_reg;
    logic [31:0]        root_len_reg;
    logic signed [63:0] area_out_reg;
    logic [30:0]        len_out_reg;
    logic [NODE_W-1:0]  clr_cnt_reg;

    // walk stack
    logic [NODE_W:0]    stk_node [DEPTH];
    logic [TW-1:0]      stk_lo   [DEPTH];
    logic [TW-1:0]      stk_hi   [DEPTH];
    logic               stk_post [DEPTH];
    logic [SPC-1:0]     sp_reg;

    // read data
    logic [15:0] cnt_q;
    logic [31:0] la_q, lb_q, tlo_q, thi_q;
    logic        a_ok_q, b_ok_q;

    // range clipping
    logic [31:0]   qlo_w, qhi_w;
    logic          empty;
    logic [TW-1:0] qlo_t, qhi_t;

    assign qlo_w = (rlo_reg == 11'd0) ? 32'd1 : 32'(rlo_reg);
    assign qhi_w = (32'(rhi_reg) > 32'(used_leaves)) ? 32'(used_leaves) : 32'(rhi_reg);
    assign empty = qlo_w > qhi_w;
    assign qlo_t = TW'(qlo_w);
    assign qhi_t = TW'(qhi_w);

    // top of stack
    logic [SPI-1:0]  top_i;
    logic [NODE_W:0] t_node;
    logic [TW-1:0]   t_lo, t_hi, mid;
    logic [TW:0]     mid_sum;
    logic            t_post, t_full, go_left, go_right;

    assign top_i    = SPI'(sp_reg - SPC'(1));
    assign t_node   = stk_node[top_i];
    assign t_lo     = stk_lo[top_i];
    assign t_hi     = stk_hi[top_i];
    assign t_post   = stk_post[top_i];
    assign mid_sum  = {1'b0, t_lo} + {1'b0, t_hi};
    assign mid      = mid_sum[TW:1];
    assign t_full   = (qlo_t <= t_lo) && (t_hi <= qhi_t);
    assign go_left  = mid >= qlo_t;
    assign go_right = mid < qhi_t;

    // child addresses
    logic [NODE_W:0]   ca, cb;
    logic [NODE_W-1:0] na;
    assign na = t_node[NODE_W-1:0];
    assign ca = {t_node[NODE_W-1:0], 1'b0};
    assign cb = {t_node[NODE_W-1:0], 1'b1};

    // status
    assign sts.clr_done  = clr_cnt_reg == NODE_W'(TREE - 1);
    assign sts.is_edge   = op_reg == OP_EDGE;
    assign sts.stk_empty = sp_reg == '0;
    assign sts.top_oob   = 32'(t_node) >= 32'(TREE);
    assign sts.top_visit = t_post || t_full;

    // node refresh
    logic [15:0] cnt_new;
    logic [31:0] len_new;
    always_comb
    begin
        cnt_new = t_post ? cnt_q : cnt_q + {{14{d_reg[1]}}, d_reg};
        if (cnt_new != 16'd0)
            len_new = thi_q - tlo_q;
        else if (t_lo == t_hi)
            len_new = 32'd0;
        else
            len_new = (a_ok_q ? la_q : 32'd0) + (b_ok_q ? lb_q : 32'd0);
    end

    // coordinate table
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_wr && (32'(cidx_reg) < 32'(TDEPTH)))
            tab_mem[TW'(cidx_reg)] <= {cval_reg[30], cval_reg};
        if (cmd.issue_rd)
        begin
            tlo_q <= tab_mem[t_lo];
            thi_q <= tab_mem[t_hi + TW'(1)];
        end
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            cnt_mem[clr_cnt_reg] <= 16'd0;
        else if (cmd.write_node && !t_post)
            cnt_mem[na] <= cnt_new;
        if (cmd.issue_rd)
            cnt_q <= cnt_mem[na];
    end

    // length memory
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            len_mem[clr_cnt_reg] <= 32'd0;
        else if (cmd.write_node)
            len_mem[na] <= len_new;
        if (cmd.issue_rd)
        begin
            la_q   <= len_mem[ca[NODE_W-1:0]];
            lb_q   <= len_mem[cb[NODE_W-1:0]];
            a_ok_q <= 32'(ca) < 32'(TREE);
            b_ok_q <= 32'(cb) < 32'(TREE);
        end
    end

    // transaction latch
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= opcode;
            cidx_reg <= coord_index;
            cval_reg <= coord_value;
            y_reg    <= edge_y;
            rlo_reg  <= range_low;
            rhi_reg  <= range_high;
            d_reg    <= delta;
        end
    end

    // area step and root length
    logic signed [31:0] gap;
    assign gap = $signed({y_reg[30], y_reg}) - $signed({prev_y_reg[30], prev_y_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_y_reg   <= '0;
            prod_reg     <= '0;
            area_reg     <= '0;
            root_len_reg <= '0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
            if (cmd.mul)
            begin
                prod_reg   <= $signed(root_len_reg) * gap;
                prev_y_reg <= y_reg;
            end
            if (cmd.acc)
                area_reg <= area_reg + prod_reg;
            if (cmd.write_node && (t_node == (NODE_W+1)'(1)))
                root_len_reg <= len_new;
        end
    end

    // stack pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sp_reg <= '0;
        else if (cmd.acc)
            sp_reg <= empty ? SPC'(0) : SPC'(1);
        else if (cmd.push_kids)
            sp_reg <= sp_reg + SPC'(go_left) + SPC'(go_right);
        else if (cmd.pop)
            sp_reg <= sp_reg - SPC'(1);
    end

    // stack frames
    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            stk_node[0] <= (NODE_W+1)'(1);
            stk_lo[0]   <= TW'(1);
            stk_hi[0]   <= used_leaves;
            stk_post[0] <= 1'b0;
        end
        else if (cmd.push_kids)
        begin
            stk_post[top_i] <= 1'b1;
            if (go_right)
            begin
                stk_node[SPI'(sp_reg)] <= cb;
                stk_lo[SPI'(sp_reg)]   <= mid + TW'(1);
                stk_hi[SPI'(sp_reg)]   <= t_hi;
                stk_post[SPI'(sp_reg)] <= 1'b0;
            end
            if (go_left)
            begin
                stk_node[SPI'(sp_reg + SPC'(go_right))] <= ca;
                stk_lo[SPI'(sp_reg + SPC'(go_right))]   <= t_lo;
                stk_hi[SPI'(sp_reg + SPC'(go_right))]   <= mid;
                stk_post[SPI'(sp_reg + SPC'(go_right))] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            area_out_reg <= area_reg;
            len_out_reg  <= root_len_reg[30:0];
        end
    end

    assign area           = area_out_reg;
    assign covered_length = len_out_reg;

endmodule

// ===== src/rectangle_union_area_sweep.sv =====
// ----------------------------------------------------------------------------
// rectangle_union_area_sweep
// Scanline union area engine with a coverage-count segment tree.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | opcode, coord_index, coord_value,
//         |           |                    | edge_y, range_low, range_high, delta
// out     | output    | out_valid/out_stall| area, covered_length
// cfg     | input     | apb psel/penable   | used_leaves at address 0
//
// a load transaction goes through decode to the handoff state; an edge
// transaction adds the area step, then walks the tree, splitting each partial
// node and refreshing each visited node by a read and then a write of the
// count and length memories.
// after reset a clearing pass zeroes all 4*MAX_LEAVES tree memory entries.
// a finished result waits in the output register while out_stall is high; the
// next transaction is accepted meanwhile but completes only when it drains.
// ----------------------------------------------------------------------------
module rectangle_union_area_sweep #(
    parameter int MAX_LEAVES = rua_pkg::MAX_LEAVES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               opcode,
    input  logic [10:0]        coord_index,
    input  logic signed [30:0] coord_value,
    input  logic signed [30:0] edge_y,
    input  logic [10:0]        range_low,
    input  logic [10:0]        range_high,
    input  logic signed [1:0]  delta,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [63:0] area,
    output logic [30:0]        covered_length
);
    import rua_pkg::*;

    localparam int TW = $clog2(MAX_LEAVES + 2);

    cmd_t    cmd;
    status_t sts;

    logic [TW-1:0] used_reg, used_next;
    logic [10:0]   wv;

    // leaf count register with clamping
    assign wv = pwdata[10:0];
    always_comb
    begin
        used_next = used_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_USED_LEAVES))
        begin
            if (wv == 11'd0)
                used_next = TW'(1);
            else if (32'(wv) > 32'(MAX_LEAVES))
                used_next = TW'(MAX_LEAVES);
            else
                used_next = TW'(wv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            used_reg <= TW'(1);
        else
            used_reg <= used_next;
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_USED_LEAVES) ? 32'(used_reg) : 32'd0;

    rua_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rua_dp #(
        .MAX_LEAVES (MAX_LEAVES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .used_leaves    (used_reg),
        .opcode         (opcode),
        .coord_index    (coord_index),
        .coord_value    (coord_value),
        .edge_y         (edge_y),
        .range_low      (range_low),
        .range_high     (range_high),
        .delta          (delta),
        .area           (area),
        .covered_length (covered_length)
    );

endmodule

// ===== tb/sv/tb_rectangle_union_area_sweep.sv =====
// ----------------------------------------------------------------------------
// tb_rectangle_union_area_sweep
// Self-checking bench for the union area sweep: a queue-fed driver, a
// monitor, and a segment tree predictor of the running area and the covered
// length, checked in order against every output transaction.
// ----------------------------------------------------------------------------
module tb_rectangle_union_area_sweep;
    import rua_pkg::*;

    localparam int LEAVES = 1024;
    localparam int NODES = 4 * LEAVES;
    localparam int TBL = LEAVES + 2;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic               op;
        logic [10:0]        idx;
        logic signed [30:0] xval;
        logic signed [30:0] y;
        logic [10:0]        lo;
        logic [10:0]        hi;
        logic signed [1:0]  d;
    } txn_t;

    typedef struct packed {
        logic signed [63:0] area;
        logic [30:0]        len;
    } res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic opcode = 1'b0;
    logic [10:0] coord_index = '0;
    logic signed [30:0] coord_value = '0;
    logic signed [30:0] edge_y = '0;
    logic [10:0] range_low = '0;
    logic [10:0] range_high = '0;
    logic signed [1:0] delta = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [63:0] area;
    logic [30:0] covered_length;

    rectangle_union_area_sweep dut (.*);

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic [31:0] xs_table [TBL];
    logic [15:0] cnt [NODES];
    logic [31:0] seglen [NODES];
    logic [31:0] last_y;
    logic [63:0] area_acc;
    int unsigned leaves;

    txn_t pending_q[$];
    res_t area_q[$];
    int errors = 0;
    int long_hold = 0;
    int idle_cycles = 0;

    function automatic logic [31:0] xs_at(int unsigned i);
        return (i < TBL) ? xs_table[i] : 32'd0;
    endfunction

    function automatic void refresh_node(int unsigned n, int unsigned lo, int unsigned hi);
        logic [31:0] a, b;
        if (n >= NODES)
            return;
        a = (2 * n < NODES) ? seglen[2 * n] : 32'd0;
        b = (2 * n + 1 < NODES) ? seglen[2 * n + 1] : 32'd0;
        if (cnt[n] != 0)
            seglen[n] = xs_at(hi + 1) - xs_at(lo);
        else if (lo == hi)
            seglen[n] = 0;
        else
            seglen[n] = a + b;
    endfunction

    function automatic void cover_update(int unsigned n, int unsigned lo, int unsigned hi,
                                         int unsigned qlo, int unsigned qhi, logic [15:0] d);
        int unsigned mid;
        if (n >= NODES)
            return;
        if (qlo <= lo && hi <= qhi)
        begin
            cnt[n] = cnt[n] + d;
            refresh_node(n, lo, hi);
            return;
        end
        mid = (lo + hi) >> 1;
        if (mid >= qlo)
            cover_update(2 * n, lo, mid, qlo, qhi, d);
        if (mid < qhi)
            cover_update(2 * n + 1, mid + 1, hi, qlo, qhi, d);
        refresh_node(n, lo, hi);
    endfunction

    // expected area and covered length after one transaction
    function automatic res_t predict_area(txn_t t);
        res_t r;
        logic signed [63:0] gap, len;
        int unsigned qlo, qhi;
        if (t.op == OP_LOAD)
        begin
            if (t.idx < TBL)
                xs_table[t.idx] = {t.xval[30], t.xval};
        end
        else
        begin
            gap = 64'(t.y) - 64'($signed(last_y));
            len = 64'($signed(seglen[1]));
            area_acc = area_acc + len * gap;
            last_y = {t.y[30], t.y};
            qlo = (t.lo < 1) ? 1 : t.lo;
            qhi = (t.hi > leaves) ? leaves : t.hi;
            if (qlo <= qhi)
                cover_update(1, 1, leaves, qlo, qhi, {{14{t.d[1]}}, t.d});
        end
        r.area = area_acc;
        r.len = seglen[1][30:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // driver
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            area_q.push_back(predict_area(pending_q.pop_front()));
            gap_left = $urandom_range(0, 8);
        end
        if (in_valid && in_stall)
        begin
            // hold the stalled transaction
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            in_valid <= 1'b0;
        end
        else if (pending_q.size() > 0)
        begin
            {opcode, coord_index, coord_value, edge_y, range_low, range_high, delta}
                <= pending_q[0];
            in_valid <= 1'b1;
        end
        else
            in_valid <= 1'b0;
    end

    // monitor and receiver stalls
    int stall_left = 0;
    always @(posedge clk)
    begin
        res_t want;
        if (out_valid && !out_stall)
        begin
            if (area_q.size() == 0)
                report_mismatch("unexpected output", area, 64'd0);
            else
            begin
                want = area_q.pop_front();
                if (area !== want.area)
                    report_mismatch("area", area, want.area);
                if (covered_length !== want.len)
                    report_mismatch("covered_length", 64'(covered_length), 64'(want.len));
            end
            stall_left = $urandom_range(0, 8);
        end
        if (long_hold > 0)
        begin
            long_hold--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drain();
        while (area_q.size() > 0 || pending_q.size() > 0 || in_valid)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_leaves(int unsigned v);
        int unsigned vm;
        vm = v & 32'h7ff;
        @(posedge clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(4 * REG_USED_LEAVES); pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (vm > LEAVES)
            leaves = LEAVES;
        else if (vm < 1)
            leaves = 1;
        else
            leaves = vm;
    endtask

    function automatic txn_t load_txn(int unsigned i, logic signed [30:0] x);
        txn_t t;
        t = '0;
        t.op = OP_LOAD; t.idx = 11'(i); t.xval = x;
        t.y = 31'($urandom); t.lo = 11'($urandom); t.hi = 11'($urandom);
        t.d = 2'($urandom);
        return t;
    endfunction

    function automatic txn_t edge_txn(logic signed [30:0] y, int unsigned lo, int unsigned hi,
                                      logic signed [1:0] d);
        txn_t t;
        t.op = OP_EDGE; t.y = y; t.lo = 11'(lo); t.hi = 11'(hi); t.d = d;
        t.idx = 11'($urandom); t.xval = 31'($urandom);
        return t;
    endfunction

    // fill table entries 1..n+1 with sorted random coordinates
    task automatic load_table(int unsigned n, bit wide);
        logic signed [30:0] x;
        x = wide ? -31'sd1073741824 : $signed(31'($urandom_range(0, 2000))) - 31'sd1000;
        for (int unsigned i = 1; i <= n + 1; i++)
        begin
            pending_q.push_back(load_txn(i, x));
            x = wide ? x + 31'sd1048575 : x + 31'($urandom_range(0, 50));
        end
    endtask

    // one sweep of random rectangles over n leaves
    task automatic sweep(int unsigned n, int unsigned edges);
        logic signed [30:0] y;
        int unsigned lo, hi;
        y = $signed(31'($urandom_range(0, 1000))) - 31'sd500;
        for (int unsigned k = 0; k < edges; k++)
        begin
            lo = $urandom_range(0, n + 1);
            hi = $urandom_range(0, n + 1);
            if ($urandom_range(0, 9) == 0)
                y = y - 31'($urandom_range(0, 5));
            else
                y = y + 31'($urandom_range(0, 100));
            if ($urandom_range(0, 19) == 0)
                pending_q.push_back(edge_txn(31'($urandom), $urandom, $urandom,
                                             2'($urandom)));
            else
                pending_q.push_back(edge_txn(y, lo, hi, ($urandom_range(0, 3) == 0) ?
                                    -2'sd1 : 2'sd1));
        end
    endtask

    initial
    begin
        int unsigned n;
        for (int i = 0; i < TBL; i++)
            xs_table[i] = 0;
        for (int i = 0; i < NODES; i++)
        begin
            cnt[i] = 0;
            seglen[i] = 0;
        end
        last_y = 0;
        area_acc = 0;
        leaves = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: defaults, extremes, all delta codes, empty and clipped ranges
        write_leaves(4);
        pending_q.push_back(load_txn(0, 31'sd5));
        pending_q.push_back(load_txn(1, -31'sd1073741824));
        pending_q.push_back(load_txn(2, 31'sd0));
        pending_q.push_back(load_txn(3, 31'sd1073741823));
        pending_q.push_back(load_txn(4, 31'sd1073741823));
        pending_q.push_back(load_txn(5, -31'sd1073741824));
        pending_q.push_back(load_txn(2047, 31'sd7));
        pending_q.push_back(edge_txn(-31'sd1073741824, 1, 2, 2'sd1));
        pending_q.push_back(edge_txn(31'sd1073741823, 0, 2047, 2'sd1));
        pending_q.push_back(edge_txn(31'sd0, 3, 2, 2'sd1));
        pending_q.push_back(edge_txn(31'sd100, 2, 3, -2'sd2));
        pending_q.push_back(edge_txn(31'sd50, 4, 4, 2'sd0));
        pending_q.push_back(edge_txn(31'sd60, 0, 0, -2'sd1));
        pending_q.push_back(edge_txn(31'sd1073741823, 1, 4, -2'sd1));
        pending_q.push_back(load_txn(1025, 31'sd3));
        wait_drain();

        // leaf count of zero and above the maximum, tree kept across settings
        write_leaves(0);
        pending_q.push_back(edge_txn(31'sd70, 1, 1, 2'sd1));
        pending_q.push_back(edge_txn(31'sd80, 1, 1, -2'sd1));
        wait_drain();
        write_leaves(2047);
        load_table(LEAVES, 1'b1);
        sweep(LEAVES, 30);
        wait_drain();

        // sender pause until drained, then long receiver hold while sending
        write_leaves(LEAVES);
        sweep(LEAVES, 20);
        long_hold = 400;
        wait_drain();

        // random sweeps at several leaf counts
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph % 5)
                0: n = 1;
                1: n = 2;
                2: n = $urandom_range(3, 16);
                3: n = $urandom_range(17, 100);
                default: n = $urandom_range(3, 40);
            endcase
            write_leaves(n);
            load_table(n, 1'b0);
            sweep(n, 16);
            wait_drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
